// ===== hw/rtl/eudst_pkg.sv =====
`default_nettype none

package eudst_pkg;

    localparam int unsigned YEARS = 100;
    localparam int unsigned YEAR_W = 7;
    localparam int unsigned DAYS_W = 16;
    localparam int unsigned QUAD_W = 6;

    localparam logic [31:0] EPOCH_2000_S = 32'd946684800;
    localparam logic [12:0] SUMMER_OFFSET = 13'd7200;
    localparam logic [12:0] WINTER_OFFSET = 13'd3600;

    localparam longint unsigned SECS_PER_DAY = 86400;
    localparam longint unsigned DAYS_TO_2000 = 10957;
    localparam longint unsigned WEEK_DAYS = 7;
    localparam longint unsigned SWITCH_HOUR_S = 3600;
    localparam longint unsigned QUAD_DAYS = 1461;

    // day-of-year (zero based) of the 31st of march and of october, non-leap
    localparam int unsigned MARCH_31_DOY = 89;
    localparam int unsigned OCTOBER_31_DOY = 303;

    // seconds / 86400 = (seconds >> 7) / 675, done by reciprocal multiply
    localparam int unsigned DAY_SHIFT = 7;
    localparam longint unsigned DAY_DIV = 675;
    localparam int unsigned DAY_RECIP_SH = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_RECIP_SH) + DAY_DIV - 64'd1) / DAY_DIV);

    // days / 1461 for a 16-bit day count
    localparam int unsigned QUAD_RECIP_SH = 27;
    localparam logic [16:0] QUAD_RECIP =
        17'(((64'd1 << QUAD_RECIP_SH) + QUAD_DAYS - 64'd1) / QUAD_DAYS);

    typedef logic [YEARS-1:0][31:0] instant_tbl_t;

    // utc instant of 01:00 on the last sunday of a 31-day month, per year
    function automatic instant_tbl_t build_tbl(input int unsigned doy31);
        instant_tbl_t tbl;
        longint unsigned leap;
        longint unsigned ys;
        longint unsigned d31;
        longint unsigned dow;
        tbl = '0;
        for (int unsigned yi = 0; yi < YEARS; yi++) begin
            leap = ((yi % 4) == 0) ? 64'd1 : 64'd0;
            ys = DAYS_TO_2000 + longint'(yi) * 365 + (longint'(yi) + 3) / 4;
            d31 = ys + longint'(doy31) + leap;
            dow = (d31 + 4) % WEEK_DAYS;
            tbl[yi] = 32'((d31 - dow) * SECS_PER_DAY + SWITCH_HOUR_S);
        end
        return tbl;
    endfunction

    localparam instant_tbl_t START_TBL = build_tbl(MARCH_31_DOY);
    localparam instant_tbl_t END_TBL = build_tbl(OCTOBER_31_DOY);

endpackage

`default_nettype wire

// ===== hw/rtl/eu_dst_utc_offset_top.sv =====
// channel | ports                                               | direction
// s_      | s_valid, s_ready, s_utc_seconds[31:0]               | in
// m_      | m_valid, m_ready, m_summer_time, m_offset_seconds[12:0],
//         | m_local_seconds[31:0]                               | out
//
// six register stages: epoch offset, day divide, four-year divide, year index,
// switch instant lookup, compare and add into the output register.
// one timestamp per cycle unless a stall on m_ready holds the pipeline.
// aresetn (synchronous, active low) empties every stage.
// a stall on m_ready freezes all stages together; nothing is dropped or repeated.
`default_nettype none

module eu_dst_utc_offset_top import eudst_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_utc_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_summer_time,
    output logic [12:0]      m_offset_seconds,
    output logic [31:0]      m_local_seconds
);

    logic adv;
    logic [4:0] vld_reg;
    logic out_vld_reg;

    // stage 1
    logic [31:0] utc1_reg;
    logic [24:0] dsh1_reg;
    logic [31:0] diff;
    // stage 2
    logic [31:0] utc2_reg;
    logic [DAYS_W-1:0] days2_reg;
    logic [50:0] day_prod;
    // stage 3
    logic [31:0] utc3_reg;
    logic [DAYS_W-1:0] days3_reg;
    logic [QUAD_W-1:0] quad3_reg;
    logic [32:0] quad_prod;
    // stage 4
    logic [31:0] utc4_reg;
    logic [YEAR_W-1:0] yi4_reg;
    logic [DAYS_W-1:0] rest;
    logic [1:0] yr_in_quad;
    logic [7:0] yi_wide;
    logic [YEAR_W-1:0] yi_next;
    // stage 5
    logic [31:0] utc5_reg;
    logic [31:0] start5_reg;
    logic [31:0] end5_reg;
    // output
    logic summer;
    logic [12:0] offset;
    logic summer_reg;
    logic [12:0] offset_reg;
    logic [31:0] local_reg;

    assign adv = !out_vld_reg || m_ready;
    assign s_ready = adv;

    assign diff = s_utc_seconds - EPOCH_2000_S;
    assign day_prod = 51'(dsh1_reg) * 51'(DAY_RECIP);
    assign quad_prod = 33'(days2_reg) * 33'(QUAD_RECIP);

    always_comb begin
        rest = days3_reg - DAYS_W'(17'(quad3_reg) * 17'(QUAD_DAYS));
        if (rest < DAYS_W'(366)) begin
            yr_in_quad = 2'd0;
        end else if (rest < DAYS_W'(731)) begin
            yr_in_quad = 2'd1;
        end else if (rest < DAYS_W'(1096)) begin
            yr_in_quad = 2'd2;
        end else begin
            yr_in_quad = 2'd3;
        end
        yi_wide = {quad3_reg, 2'b00} + 8'(yr_in_quad);
        yi_next = (yi_wide > 8'(YEARS - 1)) ? YEAR_W'(YEARS - 1) : yi_wide[YEAR_W-1:0];
    end

    assign summer = (utc5_reg >= start5_reg) && (utc5_reg < end5_reg);
    assign offset = summer ? SUMMER_OFFSET : WINTER_OFFSET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], s_valid};
            out_vld_reg <= vld_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            utc1_reg <= s_utc_seconds;
            // before 2000 the day count clamps to zero
            dsh1_reg <= (s_utc_seconds < EPOCH_2000_S) ? '0 : diff[31:DAY_SHIFT];

            utc2_reg <= utc1_reg;
            days2_reg <= day_prod[DAY_RECIP_SH +: DAYS_W];

            utc3_reg <= utc2_reg;
            days3_reg <= days2_reg;
            quad3_reg <= quad_prod[QUAD_RECIP_SH +: QUAD_W];

            utc4_reg <= utc3_reg;
            yi4_reg <= yi_next;

            utc5_reg <= utc4_reg;
            start5_reg <= START_TBL[yi4_reg];
            end5_reg <= END_TBL[yi4_reg];

            summer_reg <= summer;
            offset_reg <= offset;
            local_reg <= utc5_reg + 32'(offset);
        end
    end

    assign m_valid = out_vld_reg;
    assign m_summer_time = summer_reg;
    assign m_offset_seconds = offset_reg;
    assign m_local_seconds = local_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/eudst_checker.sv =====
`default_nettype none

module eudst_checker import eudst_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_summer_time,
    input wire logic [12:0] m_offset_seconds,
    input wire logic [31:0] m_local_seconds
);

    // a stalled result holds its fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_summer_time)
            && $stable(m_offset_seconds) && $stable(m_local_seconds))
        else $error("result changed under stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_summer_time && m_offset_seconds == SUMMER_OFFSET)
            || (!m_summer_time && m_offset_seconds == WINTER_OFFSET))
        else $error("offset does not match summer flag");

    // summer time only exists between march 2000 and october 2099
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_summer_time |->
            m_local_seconds > 32'd954000000 && m_local_seconds < 32'd4100000000)
        else $error("summer time outside the covered years");

    // the pipeline is empty after reset, so no result can appear at once
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

bind eu_dst_utc_offset_top eudst_checker u_eudst_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_summer_time    (m_summer_time),
    .m_offset_seconds (m_offset_seconds),
    .m_local_seconds  (m_local_seconds)
);

`default_nettype wire
